// ----- hw/rtl/hlc_pkg.sv -----
// Shared types and constants of the homogeneous line clipper.
// Used by every module of the block; depends on nothing.
package hlc_pkg;

   localparam int COORD_W    = 32;
   localparam int T_FRAC     = 16;
   localparam int T_W        = T_FRAC + 1;
   localparam int NUM_W      = COORD_W + 2;
   localparam int MAG_W      = NUM_W;
   localparam int REM_W      = MAG_W + 1;
   localparam int NUM_LANES  = 6;
   localparam int DIV_STEPS  = 2;
   localparam int DIV_STAGES = (T_FRAC + DIV_STEPS - 1) / DIV_STEPS;
   localparam int QDEPTH     = 8;
   localparam int QPTR_W     = $clog2(QDEPTH);
   localparam int OCC_W      = $clog2(QDEPTH + 1);

   localparam logic [T_W-1:0] ONE_T = {1'b1, {T_FRAC{1'b0}}};

   // Index 0 is x, 1 is y, 2 is z, 3 is w.
   typedef logic [3:0][COORD_W-1:0] vec_type;

   // One clipped segment as it waits between the front and the back.
   typedef struct packed {
      vec_type          a;
      vec_type          b;
      logic             empty;
      logic [T_W-1:0]   t_min;
      logic [T_W-1:0]   t_max;
   } seg_type;

   typedef struct packed {
      vec_type          v;
      logic [T_W-1:0]   weight;
      logic             last;
   } rsp_type;

endpackage

// ----- hw/rtl/hlc_front.sv -----
// Front of the clipper: constraint setup, pipelined fraction dividers and
// range reduction. Depends on hlc_pkg.
module hlc_front
   import hlc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   input  vec_type in_a,
   input  vec_type in_b,
   output logic    out_valid,
   output seg_type out_seg
);

   typedef struct packed {
      logic             upper;
      logic             empty;
      logic             div;
      logic [T_W-1:0]   q;
      logic [REM_W-1:0] rem;
      logic [MAG_W-1:0] d;
   } lane_type;

   localparam int NPOS = DIV_STAGES + 2;

   logic signed [NUM_W-1:0] num_in [NUM_LANES];
   logic signed [NUM_W-1:0] den_in [NUM_LANES];
   logic signed [NUM_W-1:0] num_ff [NUM_LANES];
   logic signed [NUM_W-1:0] den_ff [NUM_LANES];
   logic signed [NUM_W-1:0] ax, aw, dc, dw;
   logic signed [NUM_W-1:0] n_b [NUM_LANES];
   logic signed [NUM_W-1:0] d_b [NUM_LANES];

   lane_type lane_b_in [NUM_LANES];
   lane_type lane_ff   [DIV_STAGES+1][NUM_LANES];
   lane_type lane_in   [DIV_STAGES][NUM_LANES];

   logic    vld_ff [NPOS];
   vec_type a_ff   [NPOS];
   vec_type b_ff   [NPOS];

   logic [T_W-1:0] qf [NUM_LANES];
   logic [T_W-1:0] tmin_c, tmax_c;
   logic           empty_c;

   logic    out_valid_ff;
   seg_type out_seg_ff;

   function automatic lane_type div_step(lane_type l);
      lane_type         r;
      logic [REM_W-1:0] rem2;
      r    = l;
      rem2 = {l.rem[REM_W-2:0], 1'b0};
      if (l.div) begin
         r.q = {l.q[T_W-2:0], 1'b0};
         if (rem2 >= {1'b0, l.d}) begin
            rem2   = rem2 - {1'b0, l.d};
            r.q[0] = 1'b1;
         end
         r.rem = rem2;
      end
      return r;
   endfunction

   // Each axis gives two constraints num <= t * den.
   always_comb begin
      aw = NUM_W'($signed(in_a[3]));
      dw = NUM_W'($signed(in_b[3])) - aw;
      for (int c = 0; c < 3; c++) begin
         ax = NUM_W'($signed(in_a[c]));
         dc = NUM_W'($signed(in_b[c])) - ax;
         num_in[2*c]   = -aw - ax;
         den_in[2*c]   = dc + dw;
         num_in[2*c+1] = ax - aw;
         den_in[2*c+1] = dw - dc;
      end
   end

   // A negative slope bounds t from above; magnitudes feed the divider.
   always_comb begin
      for (int l = 0; l < NUM_LANES; l++) begin
         n_b[l] = den_ff[l][NUM_W-1] ? -num_ff[l] : num_ff[l];
         d_b[l] = den_ff[l][NUM_W-1] ? -den_ff[l] : den_ff[l];
         lane_b_in[l].upper = den_ff[l][NUM_W-1];
         lane_b_in[l].empty = (den_ff[l] == '0) && (num_ff[l] > 0);
         lane_b_in[l].div   = (den_ff[l] != '0) && (n_b[l] > 0) && (n_b[l] < d_b[l]);
         lane_b_in[l].q     = ((den_ff[l] != '0) && (n_b[l] > 0) && (n_b[l] >= d_b[l]))
                              ? ONE_T : '0;
         lane_b_in[l].rem   = REM_W'($unsigned(n_b[l]));
         lane_b_in[l].d     = MAG_W'($unsigned(d_b[l]));
      end
   end

   always_comb begin
      for (int s = 0; s < DIV_STAGES; s++) begin
         for (int l = 0; l < NUM_LANES; l++) begin
            lane_in[s][l] = lane_ff[s][l];
            for (int k = 0; k < DIV_STEPS; k++) begin
               if (s * DIV_STEPS + k < T_FRAC) begin
                  lane_in[s][l] = div_step(lane_in[s][l]);
               end
            end
         end
      end
   end

   // Lower bounds round up, then the range is narrowed.
   always_comb begin
      tmin_c  = '0;
      tmax_c  = ONE_T;
      empty_c = 1'b0;
      for (int l = 0; l < NUM_LANES; l++) begin
         qf[l] = lane_ff[DIV_STAGES][l].q;
         if (lane_ff[DIV_STAGES][l].div && !lane_ff[DIV_STAGES][l].upper &&
             (lane_ff[DIV_STAGES][l].rem != '0)) begin
            qf[l] = qf[l] + T_W'(1);
         end
         if (lane_ff[DIV_STAGES][l].empty) begin
            empty_c = 1'b1;
         end
         if (lane_ff[DIV_STAGES][l].upper) begin
            if (qf[l] < tmax_c) begin
               tmax_c = qf[l];
            end
         end else if (qf[l] > tmin_c) begin
            tmin_c = qf[l];
         end
      end
      if (!(tmin_c < tmax_c)) begin
         empty_c = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int p = 0; p < NPOS; p++) begin
            vld_ff[p] <= 1'b0;
         end
         out_valid_ff <= 1'b0;
      end else begin
         vld_ff[0] <= in_valid;
         for (int p = 1; p < NPOS; p++) begin
            vld_ff[p] <= vld_ff[p-1];
         end
         out_valid_ff <= vld_ff[NPOS-1];
      end
      a_ff[0] <= in_a;
      b_ff[0] <= in_b;
      for (int p = 1; p < NPOS; p++) begin
         a_ff[p] <= a_ff[p-1];
         b_ff[p] <= b_ff[p-1];
      end
      for (int l = 0; l < NUM_LANES; l++) begin
         num_ff[l]     <= num_in[l];
         den_ff[l]     <= den_in[l];
         lane_ff[0][l] <= lane_b_in[l];
         for (int s = 0; s < DIV_STAGES; s++) begin
            lane_ff[s+1][l] <= lane_in[s][l];
         end
      end
      out_seg_ff.a     <= a_ff[NPOS-1];
      out_seg_ff.b     <= b_ff[NPOS-1];
      out_seg_ff.empty <= empty_c;
      out_seg_ff.t_min <= tmin_c;
      out_seg_ff.t_max <= tmax_c;
   end

   assign out_valid = out_valid_ff;
   assign out_seg   = out_seg_ff;

endmodule

// ----- hw/rtl/hlc_queue.sv -----
// Small segment queue between the front and the back of the clipper.
// Depends on hlc_pkg.
module hlc_queue
   import hlc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  seg_type push_seg,
   input  logic    pop,
   output logic    avail,
   output logic    full,
   output seg_type head_seg
);

   seg_type          mem_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [OCC_W-1:0]  count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + OCC_W'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - OCC_W'(1);
         end
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_seg;
      end
   end

   assign avail    = (count_ff != '0);
   assign full     = (count_ff == OCC_W'(QDEPTH));
   assign head_seg = mem_ff[rd_ptr_ff];

endmodule

// ----- hw/rtl/hlc_back.sv -----
// Back of the clipper: interpolates the start and end vertex of each kept
// segment, one vertex per cycle while it works on one. Depends on hlc_pkg.
module hlc_back
   import hlc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    flat,
   input  logic    q_avail,
   input  seg_type head_seg,
   output logic    pop,
   output logic    rsp_valid,
   output rsp_type rsp
);

   localparam int D_W   = COORD_W + 1;
   localparam int HI_W  = D_W - T_FRAC;
   localparam int RES_W = COORD_W + T_W + 2;

   seg_type        cur_ff;
   logic           cur_valid_ff;
   logic           phase_ff;
   logic           rsp_valid_ff;
   rsp_type        rsp_ff;
   logic [T_W-1:0] t_sel;
   logic           active;
   logic           done;
   vec_type        v_in;

   // a + round((b - a) * t), with the difference split at the binary point.
   function automatic logic [COORD_W-1:0] interp(logic [COORD_W-1:0] a,
                                                 logic [COORD_W-1:0] b,
                                                 logic [T_W-1:0] t);
      logic signed [D_W-1:0]        d;
      logic        [T_FRAC-1:0]     lo;
      logic signed [HI_W-1:0]       hi;
      logic        [T_FRAC+T_W:0]   prod_lo;
      logic signed [HI_W+T_W:0]     prod_hi;
      logic signed [RES_W-1:0]      res;
      d       = D_W'($signed(b)) - D_W'($signed(a));
      lo      = d[T_FRAC-1:0];
      hi      = d[D_W-1:T_FRAC];
      prod_lo = (T_FRAC+T_W+1)'(lo) * (T_FRAC+T_W+1)'(t)
                + (T_FRAC+T_W+1)'(ONE_T >> 1);
      prod_hi = (HI_W+T_W+1)'(hi) * $signed({1'b0, t});
      res     = RES_W'($signed(a)) + RES_W'(prod_hi)
                + RES_W'(prod_lo[T_FRAC+T_W:T_FRAC]);
      return res[COORD_W-1:0];
   endfunction

   always_comb begin
      t_sel  = phase_ff ? cur_ff.t_max : cur_ff.t_min;
      active = cur_valid_ff && !cur_ff.empty;
      done   = !cur_valid_ff || cur_ff.empty || phase_ff;
      pop    = done && q_avail;
      for (int c = 0; c < 4; c++) begin
         v_in[c] = interp(cur_ff.a[c], cur_ff.b[c], t_sel);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         phase_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= active;
         if (pop) begin
            cur_valid_ff <= 1'b1;
            phase_ff     <= 1'b0;
         end else if (done) begin
            cur_valid_ff <= 1'b0;
            phase_ff     <= 1'b0;
         end else begin
            phase_ff <= 1'b1;
         end
      end
      if (pop) begin
         cur_ff <= head_seg;
      end
      rsp_ff.v      <= v_in;
      rsp_ff.weight <= flat ? '0 : t_sel;
      rsp_ff.last   <= phase_ff;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

// ----- hw/rtl/homogeneous_line_clipper_core.sv -----
// Top level of the homogeneous line clipper.
// Instantiates hlc_front, hlc_queue and hlc_back; depends on hlc_pkg.
//
// The block clips one line segment, given as two clip-space endpoints, against
// -w <= x, y, z <= w and emits the start and end vertex of the kept part on
// consecutive cycles (rsp_is_last marks the second), or nothing when the segment
// lies outside. A transaction is accepted on a rising edge with start high and
// busy low; results are strobed by rsp_valid for one cycle each and cannot be
// held off. The back end produces one vertex per cycle while it works on a kept
// segment and takes the next segment with the end vertex. A segment passes two
// setup stages, an eight-stage divider pipeline (two quotient bits per stage,
// six lanes), one reduction stage, the queue, the segment register and the
// interpolation register. busy rises when every queue slot is claimed by a
// segment in flight or queued. The user must write flat_interp through
// csr_wr_en/csr_wr_data only while the block is idle, which it does not enforce.
module homogeneous_line_clipper_core
   import hlc_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic signed [COORD_W-1:0] req_a_x,
   input  logic signed [COORD_W-1:0] req_a_y,
   input  logic signed [COORD_W-1:0] req_a_z,
   input  logic signed [COORD_W-1:0] req_a_w,
   input  logic signed [COORD_W-1:0] req_b_x,
   input  logic signed [COORD_W-1:0] req_b_y,
   input  logic signed [COORD_W-1:0] req_b_z,
   input  logic signed [COORD_W-1:0] req_b_w,
   input  logic                      csr_wr_en,
   input  logic                      csr_wr_data,
   output logic                      rsp_valid,
   output logic signed [COORD_W-1:0] rsp_out_x,
   output logic signed [COORD_W-1:0] rsp_out_y,
   output logic signed [COORD_W-1:0] rsp_out_z,
   output logic signed [COORD_W-1:0] rsp_out_w,
   output logic [T_W-1:0]            rsp_attr_weight,
   output logic                      rsp_is_last
);

   logic             flat_ff;
   logic [OCC_W-1:0] occ_ff, occ_in;
   logic             accept;
   vec_type          in_a, in_b;
   logic             q_push, q_pop, q_avail, q_full;
   seg_type          push_seg, head_seg;
   rsp_type          rsp;

   // Credits count segments accepted and not yet taken by the back end, so the
   // fixed-latency front can never overrun the queue.
   assign busy   = (occ_ff == OCC_W'(QDEPTH));
   assign accept = start && !busy;
   assign in_a   = {req_a_w, req_a_z, req_a_y, req_a_x};
   assign in_b   = {req_b_w, req_b_z, req_b_y, req_b_x};

   always_comb begin
      occ_in = occ_ff;
      if (accept && !q_pop) begin
         occ_in = occ_ff + OCC_W'(1);
      end else if (q_pop && !accept) begin
         occ_in = occ_ff - OCC_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flat_ff <= 1'b0;
         occ_ff  <= '0;
      end else begin
         occ_ff <= occ_in;
         if (csr_wr_en) begin
            flat_ff <= csr_wr_data;
         end
      end
   end

   hlc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_a      (in_a),
      .in_b      (in_b),
      .out_valid (q_push),
      .out_seg   (push_seg)
   );

   hlc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_seg (push_seg),
      .pop      (q_pop),
      .avail    (q_avail),
      .full     (q_full),
      .head_seg (head_seg)
   );

   hlc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .flat      (flat_ff),
      .q_avail   (q_avail),
      .head_seg  (head_seg),
      .pop       (q_pop),
      .rsp_valid (rsp_valid),
      .rsp       (rsp)
   );

   assign rsp_out_x       = rsp.v[0];
   assign rsp_out_y       = rsp.v[1];
   assign rsp_out_z       = rsp.v[2];
   assign rsp_out_w       = rsp.v[3];
   assign rsp_attr_weight = rsp.weight;
   assign rsp_is_last     = rsp.last;

   // The credit scheme must keep the queue from ever taking a push when full.
   assert property (@(posedge clock) disable iff (reset) q_push |-> !q_full)
      else $error("segment pushed into a full queue");

   assert property (@(posedge clock) disable iff (reset) occ_ff <= OCC_W'(QDEPTH))
      else $error("credit count beyond queue depth");

   // Vertices always come in start/end pairs on back-to-back cycles.
   assert property (@(posedge clock) disable iff (reset)
                    rsp_valid && !rsp_is_last |=> rsp_valid && rsp_is_last)
      else $error("start vertex not followed by end vertex");

   assert property (@(posedge clock) disable iff (reset)
                    rsp_valid && rsp_is_last |-> $past(rsp_valid) && !$past(rsp_is_last))
      else $error("end vertex without preceding start vertex");

endmodule

// ----- dv/hlc_checker.sv -----
// Scoreboard for the homogeneous line clipper: watches accepted segments and
// emitted vertices, predicts the clipped vertices and compares them.
// Depends on hlc_pkg.
module hlc_checker
   import hlc_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic                      busy,
   input  logic signed [COORD_W-1:0] req_a_x,
   input  logic signed [COORD_W-1:0] req_a_y,
   input  logic signed [COORD_W-1:0] req_a_z,
   input  logic signed [COORD_W-1:0] req_a_w,
   input  logic signed [COORD_W-1:0] req_b_x,
   input  logic signed [COORD_W-1:0] req_b_y,
   input  logic signed [COORD_W-1:0] req_b_z,
   input  logic signed [COORD_W-1:0] req_b_w,
   input  logic                      csr_wr_en,
   input  logic                      csr_wr_data,
   input  logic                      rsp_valid,
   input  logic signed [COORD_W-1:0] rsp_out_x,
   input  logic signed [COORD_W-1:0] rsp_out_y,
   input  logic signed [COORD_W-1:0] rsp_out_z,
   input  logic signed [COORD_W-1:0] rsp_out_w,
   input  logic [T_W-1:0]            rsp_attr_weight,
   input  logic                      rsp_is_last,
   output int                        pending,
   output int                        errors
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint ONE = longint'(1) << T_FRAC;

   rsp_type vertex_q[$];
   logic    flat_mode;

   // Ratio num/den for 0 < num < den, exact to T_FRAC bits.
   function automatic longint clip_ratio(longint num, longint den, bit round_up);
      longint rem;
      longint q;
      rem = num;
      q = 0;
      for (int i = 0; i < T_FRAC; i++) begin
         rem = rem * 2;
         q = q * 2;
         if (rem >= den) begin
            rem = rem - den;
            q = q + 1;
         end
      end
      if (round_up && rem != 0) q = q + 1;
      return q;
   endfunction

   // Applies the constraint num <= t * den to the parameter range.
   task automatic tighten(input longint num, input longint den,
                          inout longint t_lo, inout longint t_hi);
      longint q;
      if (den == 0) begin
         if (num > 0) begin
            t_lo = ONE;
            t_hi = 0;
         end
      end else if (den > 0) begin
         if (num <= 0) q = 0;
         else if (num >= den) q = ONE;
         else q = clip_ratio(num, den, 1'b1);
         if (q > t_lo) t_lo = q;
      end else begin
         if (-num <= 0) q = 0;
         else if (-num >= -den) q = ONE;
         else q = clip_ratio(-num, -den, 1'b0);
         if (q < t_hi) t_hi = q;
      end
   endtask

   // a + round((b - a) * t), ties toward plus infinity.
   function automatic logic [COORD_W-1:0] lerp(longint a, longint b, longint t);
      longint d;
      longint lo;
      longint hi;
      d = b - a;
      lo = d & (ONE - 1);
      hi = (d - lo) / ONE;
      return COORD_W'(a + hi * t + (lo * t + ONE / 2) / ONE);
   endfunction

   task automatic predict_segment(input longint a[4], input longint b[4]);
      longint  t_lo;
      longint  t_hi;
      longint  dw;
      longint  dc;
      longint  tv;
      rsp_type v;
      t_lo = 0;
      t_hi = ONE;
      dw = b[3] - a[3];
      for (int c = 0; c < 3; c++) begin
         dc = b[c] - a[c];
         tighten(-a[3] - a[c], dc + dw, t_lo, t_hi);
         tighten(a[c] - a[3], dw - dc, t_lo, t_hi);
      end
      if (t_lo < t_hi) begin
         for (int k = 0; k < 2; k++) begin
            tv = (k == 0) ? t_lo : t_hi;
            for (int j = 0; j < 4; j++) v.v[j] = lerp(a[j], b[j], tv);
            v.weight = flat_mode ? '0 : T_W'(tv);
            v.last = k[0];
            vertex_q.push_back(v);
         end
      end
   endtask

   assign pending = vertex_q.size();

   always @(posedge clock) begin
      longint  a[4];
      longint  b[4];
      rsp_type exp_v;
      rsp_type got_v;
      if (reset) begin
         flat_mode <= 1'b0;
         vertex_q.delete();
         errors <= 0;
      end else begin
         if (csr_wr_en) flat_mode <= csr_wr_data;
         if (rsp_valid) begin
            got_v.v = {rsp_out_w, rsp_out_z, rsp_out_y, rsp_out_x};
            got_v.weight = rsp_attr_weight;
            got_v.last = rsp_is_last;
            if (vertex_q.size() == 0) begin
               $display("%0t: unexpected vertex %h", $time, got_v);
               errors <= errors + 1;
            end else begin
               exp_v = vertex_q.pop_front();
               if (got_v !== exp_v) begin
                  $display("%0t: vertex mismatch: expected x=%h y=%h z=%h w=%h wt=%h last=%b",
                           $time, exp_v.v[0], exp_v.v[1], exp_v.v[2], exp_v.v[3],
                           exp_v.weight, exp_v.last);
                  $display("%0t:                  actual x=%h y=%h z=%h w=%h wt=%h last=%b",
                           $time, got_v.v[0], got_v.v[1], got_v.v[2], got_v.v[3],
                           got_v.weight, got_v.last);
                  errors <= errors + 1;
               end
            end
         end
         // Prediction after the compare: a new segment's vertices come much later.
         if (start && !busy) begin
            a = '{req_a_x, req_a_y, req_a_z, req_a_w};
            b = '{req_b_x, req_b_y, req_b_z, req_b_w};
            predict_segment(a, b);
         end
      end
   end
endmodule

// ----- dv/tb_homogeneous_line_clipper_core.sv -----
// Testbench top for homogeneous_line_clipper_core: drives segments and the
// flat_interp register, reports the verdict. Uses hlc_pkg, the core and hlc_checker.
module tb_homogeneous_line_clipper_core
   import hlc_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DRAIN_CYCLES = 40;
   localparam int STALL_LIMIT  = 2000;

   logic clock;
   logic reset;
   logic start;
   logic busy;
   logic signed [COORD_W-1:0] req_a_x, req_a_y, req_a_z, req_a_w;
   logic signed [COORD_W-1:0] req_b_x, req_b_y, req_b_z, req_b_w;
   logic csr_wr_en;
   logic csr_wr_data;
   logic rsp_valid;
   logic signed [COORD_W-1:0] rsp_out_x, rsp_out_y, rsp_out_z, rsp_out_w;
   logic [T_W-1:0] rsp_attr_weight;
   logic rsp_is_last;
   int   pending;
   int   errors;
   int   idle_cycles;

   homogeneous_line_clipper_core u_top (.*);
   hlc_checker u_checker (.*);

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   // Watchdog: counts cycles in which no transaction and no vertex was accepted.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("** homogeneous_line_clipper_core: FAILED **");
         $finish;
      end
   end

   // Offers one segment at the falling edge and holds it until it is accepted.
   // Start stays high between back-to-back segments, so it is only lowered when
   // the sender idles.
   task automatic send_segment(input logic [COORD_W-1:0] c[8], input bit hold_start);
      {req_a_x, req_a_y, req_a_z, req_a_w} <= {c[0], c[1], c[2], c[3]};
      {req_b_x, req_b_y, req_b_z, req_b_w} <= {c[4], c[5], c[6], c[7]};
      start <= 1'b1;
      do @(posedge clock); while (busy);
      @(negedge clock);
      if (!hold_start) start <= 1'b0;
   endtask

   task automatic gap_then_send(input logic [COORD_W-1:0] c[8]);
      int gap;
      gap = $urandom_range(0, 3);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      send_segment(c, 1'b1);
   endtask

   // Waits until every predicted vertex has arrived, then lets a rejected
   // segment still in the pipeline drain before the register is touched.
   task automatic drain;
      start <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_flat(input logic val);
      csr_wr_en <= 1'b1;
      csr_wr_data <= val;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic [COORD_W-1:0] q16(int whole);
      return COORD_W'(whole <<< 16);
   endfunction

   // Random segment. Mostly endpoints with w > 0 at moderate scale, so lines
   // straddle, cross or sit inside the volume; the rest is raw noise or tiny values.
   function automatic void rand_segment(output logic [COORD_W-1:0] c[8]);
      int kind;
      int w;
      kind = $urandom_range(0, 9);
      for (int e = 0; e < 2; e++) begin
         w = $urandom_range(1, 8 << 16);
         for (int j = 0; j < 3; j++) begin
            case (kind)
               0, 1:    c[e*4+j] = $urandom;
               2:       c[e*4+j] = COORD_W'($signed($urandom_range(0, 32)) - 16);
               default: c[e*4+j] = COORD_W'($signed($urandom_range(0, 4 * w)) - 2 * w);
            endcase
         end
         case (kind)
            0, 1:    c[e*4+3] = $urandom;
            2:       c[e*4+3] = COORD_W'($urandom_range(0, 16));
            default: c[e*4+3] = COORD_W'(w);
         endcase
      end
      // Occasionally copy an endpoint coordinate to hit equal slopes.
      if ($urandom_range(0, 7) == 0) c[4 + $urandom_range(0, 3)] = c[$urandom_range(0, 3)];
   endfunction

   initial begin
      logic [COORD_W-1:0] seg[8];
      logic [COORD_W-1:0] dir[$:32][8];
      logic [COORD_W-1:0] mx;
      logic [COORD_W-1:0] mn;
      reset = 1'b1;
      start = 1'b0;
      csr_wr_en = 1'b0;
      csr_wr_data = 1'b0;
      {req_a_x, req_a_y, req_a_z, req_a_w} = '0;
      {req_b_x, req_b_y, req_b_z, req_b_w} = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      mx = {1'b0, {(COORD_W-1){1'b1}}};
      mn = {1'b1, {(COORD_W-1){1'b0}}};
      // Directed segments: fully inside, crossing on each axis, fully outside,
      // equal slopes inside and outside, degenerate point, w extremes, all-ones.
      dir.push_back('{q16(0), q16(0), q16(0), q16(1), q16(1)/2, q16(0), q16(0), q16(1)});
      dir.push_back('{q16(-3), q16(0), q16(0), q16(1), q16(3), q16(0), q16(0), q16(1)});
      dir.push_back('{q16(0), q16(-3), q16(0), q16(1), q16(0), q16(3), q16(0), q16(1)});
      dir.push_back('{q16(0), q16(0), q16(-3), q16(1), q16(0), q16(0), q16(3), q16(1)});
      dir.push_back('{q16(2), q16(0), q16(0), q16(1), q16(3), q16(0), q16(0), q16(1)});
      dir.push_back('{q16(2), q16(0), q16(0), q16(1), q16(2), q16(0), q16(0), q16(1)});
      dir.push_back('{q16(0), q16(0), q16(0), q16(1), q16(0), q16(0), q16(0), q16(1)});
      dir.push_back('{q16(-1), q16(1), q16(-1), q16(1), q16(1), q16(-1), q16(1), q16(1)});
      dir.push_back('{32'd1, 32'd0, 32'd0, 32'd3, 32'd2, 32'd0, 32'd0, 32'd7});
      dir.push_back('{mn, mn, mn, mx, mx, mx, mx, mx});
      dir.push_back('{mx, mx, mx, mn, mn, mn, mn, mn});
      dir.push_back('{mn, mx, mn, mx, mx, mn, mx, mx});
      dir.push_back('{'1, '1, '1, '1, '1, '1, '1, '1});
      dir.push_back('{'0, '0, '0, '0, '0, '0, '0, '0});
      dir.push_back('{q16(0), q16(0), q16(0), q16(-1), q16(0), q16(0), q16(0), q16(1)});
      dir.push_back('{q16(5), q16(5), q16(5), q16(1), q16(-5), q16(-5), q16(-5), q16(1)});

      // Each directed segment in both interpolation modes, with the register
      // written only once the pipeline is empty.
      for (int m = 0; m < 2; m++) begin
         write_flat(m[0]);
         foreach (dir[i]) gap_then_send(dir[i]);
         drain;
      end

      // Random phases alternate the mode, ending in smooth mode; one phase sends
      // back to back with no idling.
      for (int ph = 0; ph < 8; ph++) begin
         write_flat(ph[0] ^ 1'b1);
         for (int n = 0; n < 100; n++) begin
            rand_segment(seg);
            if (ph == 3) send_segment(seg, 1'b1);
            else gap_then_send(seg);
         end
         drain;
      end

      repeat (DRAIN_CYCLES) @(negedge clock);
      if (errors == 0 && pending == 0) $display("** homogeneous_line_clipper_core: PASSED **");
      else $display("** homogeneous_line_clipper_core: FAILED **");
      $finish;
   end
endmodule

// ----- sim.f -----
hw/rtl/hlc_pkg.sv
hw/rtl/hlc_front.sv
hw/rtl/hlc_queue.sv
hw/rtl/hlc_back.sv
hw/rtl/homogeneous_line_clipper_core.sv
dv/hlc_checker.sv
dv/tb_homogeneous_line_clipper_core.sv
